// ===== design/separation_force_accumulator_assert.svh =====
// ----------------------------------------------------------------------------
// separation force accumulator assertion macros
// shared concurrent assertion forms, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef SEPARATION_FORCE_ACCUMULATOR_ASSERT_SVH
`define SEPARATION_FORCE_ACCUMULATOR_ASSERT_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define SFA_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define SFA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define SFA_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define SFA_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== design/sfa_pkg.sv =====
// ----------------------------------------------------------------------------
// sfa_pkg
// types, widths and codes shared by the separation force accumulator
// ----------------------------------------------------------------------------
package sfa_pkg;

   // fixed point format
   localparam int FRAC_BITS = 16;

   // field widths
   localparam int POS_W  = 32;
   localparam int RAD_W  = 31;
   localparam int FB_W   = 18;
   localparam int AXES   = 3;

   // datapath widths
   localparam int AW      = POS_W + 1;          // per-axis difference / magnitude
   localparam int DW      = AW + 1;             // root and divisor width
   localparam int SQ_W    = 2 * AW;             // sum of three squares
   localparam int SQ_PAD  = 2 * DW;             // radicand, two bits per root bit
   localparam int SREM_W  = DW + 2;             // root remainder
   localparam int NW      = AW + FRAC_BITS;     // dividend / quotient width
   localparam int UW      = FRAC_BITS + 1;      // unit vector component
   localparam int SL      = (NW + 1) / 2;       // low split of the scale
   localparam int SH      = NW - SL;            // high split of the scale
   localparam int PW      = UW + NW;            // full product
   localparam int MW      = PW - FRAC_BITS;     // product after rescale
   localparam int CW      = AW + 2;             // signed contribution
   localparam int ACC_W   = CW + 1;             // accumulate sum width
   localparam int CNT_W   = $clog2(NW + 1);

   // coincidence threshold in raw units
   localparam int EPS_RAW = ((1 << FRAC_BITS) + 5000) / 10000;
   localparam int EPS     = (EPS_RAW > 0) ? EPS_RAW : 1;
   localparam int EW      = $clog2(EPS + 1);
   localparam int ESQ_W   = 2 * EW + 2;

   // work queue depth
   localparam int QDEPTH  = 2;
   localparam int QPW     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCW     = $clog2(QDEPTH + 1);

   // configuration port
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   typedef enum logic [CSR_AW-1:0] {
      CSR_OWN_X      = 3'd0,
      CSR_OWN_Y      = 3'd1,
      CSR_OWN_Z      = 3'd2,
      CSR_RADIUS     = 3'd3,
      CSR_FALLBACK_X = 3'd4,
      CSR_FALLBACK_Z = 3'd5
   } sfa_csr_type;

   typedef enum logic [1:0] {
      KIND_CLOSE,
      KIND_COIN,
      KIND_FULL
   } sfa_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_SCALE,
      ST_DIV,
      ST_UNIT,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_PRODUCT,
      ST_FALLBACK,
      ST_ACC,
      ST_DONE
   } sfa_state_type;

   typedef struct packed {
      logic signed [POS_W-1:0] nbr_x;
      logic signed [POS_W-1:0] nbr_y;
      logic signed [POS_W-1:0] nbr_z;
      logic                    has_neighbor;
      logic                    last;
   } sfa_req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] force_x;
      logic signed [POS_W-1:0] force_y;
      logic signed [POS_W-1:0] force_z;
      logic                    saturated;
   } sfa_rsp_type;

   typedef struct packed {
      logic signed [POS_W-1:0] own_x;
      logic signed [POS_W-1:0] own_y;
      logic signed [POS_W-1:0] own_z;
      logic        [RAD_W-1:0] radius;
      logic signed [FB_W-1:0]  fallback_x;
      logic signed [FB_W-1:0]  fallback_z;
   } sfa_cfg_type;

   // classified item between front and back
   typedef struct packed {
      logic [AXES-1:0][AW-1:0] mag;
      logic [AXES-1:0]         neg;
      sfa_kind_type            kind;
      logic                    last;
   } sfa_work_type;

endpackage

// ===== design/separation_force_accumulator.sv =====
// ----------------------------------------------------------------------------
// separation_force_accumulator
// accumulates a saturating separation force over a list of neighbor positions
// ----------------------------------------------------------------------------
//  channel   ports                          transfer when
//  request   req_push, req_full, req_data   req_push and not req_full
//  response  rsp_pop, rsp_empty, rsp_data   rsp_pop and not rsp_empty
//  config    csr_we, csr_addr, csr_wdata    csr_we
//
//  a full neighbor runs 34 square root steps, one 49-step scale division and
//  up to three 16-step unit divisions on one shared sequencer
//  a coincident neighbor adds the fallback force on x and z, a closing item adds nothing
//  the front register and a two-entry queue take new items while the back works
//  reset is synchronous; the sums, clip flag and result valid flag clear at once
//  a finished force waits in the result register and stalls the back only there
// ----------------------------------------------------------------------------
module separation_force_accumulator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  sfa_pkg::sfa_req_type         req_data,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output sfa_pkg::sfa_rsp_type         rsp_data,
   input  logic                         csr_we,
   input  logic [sfa_pkg::CSR_AW-1:0]   csr_addr,
   input  logic [sfa_pkg::CSR_DW-1:0]   csr_wdata
);

   sfa_pkg::sfa_cfg_type  cfg_ff;
   sfa_pkg::sfa_work_type push_data, pop_data;
   logic                  q_push, q_full, q_pop, q_empty;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_x      <= '0;
         cfg_ff.own_y      <= '0;
         cfg_ff.own_z      <= '0;
         cfg_ff.radius     <= sfa_pkg::RAD_W'(1) << sfa_pkg::FRAC_BITS;
         cfg_ff.fallback_x <= sfa_pkg::FB_W'(1) << sfa_pkg::FRAC_BITS;
         cfg_ff.fallback_z <= '0;
      end else if (csr_we) begin
         case (sfa_pkg::sfa_csr_type'(csr_addr))
            sfa_pkg::CSR_OWN_X:      cfg_ff.own_x      <= csr_wdata;
            sfa_pkg::CSR_OWN_Y:      cfg_ff.own_y      <= csr_wdata;
            sfa_pkg::CSR_OWN_Z:      cfg_ff.own_z      <= csr_wdata;
            sfa_pkg::CSR_RADIUS:     cfg_ff.radius     <= csr_wdata[sfa_pkg::RAD_W-1:0];
            sfa_pkg::CSR_FALLBACK_X: cfg_ff.fallback_x <= csr_wdata[sfa_pkg::FB_W-1:0];
            sfa_pkg::CSR_FALLBACK_Z: cfg_ff.fallback_z <= csr_wdata[sfa_pkg::FB_W-1:0];
            default: begin
            end
         endcase
      end
   end

   sfa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_data   (push_data),
      .q_full   (q_full)
   );

   sfa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   sfa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_data    (pop_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== design/sfa_front.sv =====
// ----------------------------------------------------------------------------
// sfa_front
// accepts neighbor items, forms own minus neighbor and classifies each item
// ----------------------------------------------------------------------------
module sfa_front (
   input  logic                  clock,
   input  logic                  reset,
   input  sfa_pkg::sfa_cfg_type  cfg,
   input  logic                  req_push,
   output logic                  req_full,
   input  sfa_pkg::sfa_req_type  req_data,
   output logic                  q_push,
   output sfa_pkg::sfa_work_type q_data,
   input  logic                  q_full
);

   localparam logic [sfa_pkg::AW-1:0]    EPS_A  = sfa_pkg::AW'(sfa_pkg::EPS);
   localparam logic [sfa_pkg::ESQ_W-1:0] EPS_SQ =
      sfa_pkg::ESQ_W'(sfa_pkg::EPS * sfa_pkg::EPS);

   logic                                          valid_ff, valid_in;
   logic [sfa_pkg::AXES-1:0][sfa_pkg::AW-1:0]     diff_ff, diff_in;
   logic                                          has_ff, last_ff;
   logic                                          accept;

   // handshake
   assign req_full = valid_ff && q_full;
   assign accept   = req_push && !req_full;
   assign q_push   = valid_ff && !q_full;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   // per-axis difference, one bit wider than the positions
   assign diff_in[0] = {cfg.own_x[sfa_pkg::POS_W-1], cfg.own_x}
                     - {req_data.nbr_x[sfa_pkg::POS_W-1], req_data.nbr_x};
   assign diff_in[1] = {cfg.own_y[sfa_pkg::POS_W-1], cfg.own_y}
                     - {req_data.nbr_y[sfa_pkg::POS_W-1], req_data.nbr_y};
   assign diff_in[2] = {cfg.own_z[sfa_pkg::POS_W-1], cfg.own_z}
                     - {req_data.nbr_z[sfa_pkg::POS_W-1], req_data.nbr_z};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         diff_ff <= diff_in;
         has_ff  <= req_data.has_neighbor;
         last_ff <= req_data.last;
      end
   end

   // magnitudes and the coincidence test on the low bits
   always_comb begin
      logic                      small_all;
      logic [sfa_pkg::ESQ_W-1:0] sq_sum;
      logic [sfa_pkg::EW-1:0]    low;
      small_all = 1'b1;
      sq_sum    = '0;
      q_data    = '0;
      for (int i = 0; i < sfa_pkg::AXES; i++) begin
         q_data.neg[i] = diff_ff[i][sfa_pkg::AW-1];
         q_data.mag[i] = diff_ff[i][sfa_pkg::AW-1] ? (~diff_ff[i] + 1'b1) : diff_ff[i];
         small_all     = small_all && (q_data.mag[i] < EPS_A);
         low           = q_data.mag[i][sfa_pkg::EW-1:0];
         sq_sum        = sq_sum + sfa_pkg::ESQ_W'(low * low);
      end
      q_data.last = last_ff;
      if (!has_ff) begin
         q_data.kind = sfa_pkg::KIND_CLOSE;
      end else if (small_all && (sq_sum < EPS_SQ)) begin
         q_data.kind = sfa_pkg::KIND_COIN;
      end else begin
         q_data.kind = sfa_pkg::KIND_FULL;
      end
   end

endmodule

// ===== design/sfa_queue.sv =====
// ----------------------------------------------------------------------------
// sfa_queue
// short work queue between the classifying front and the arithmetic back
// ----------------------------------------------------------------------------
`include "separation_force_accumulator_assert.svh"

module sfa_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sfa_pkg::sfa_work_type push_data,
   output logic                  full,
   input  logic                  pop,
   output sfa_pkg::sfa_work_type pop_data,
   output logic                  empty
);

   sfa_pkg::sfa_work_type     entry_ff [sfa_pkg::QDEPTH];
   logic [sfa_pkg::QPW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [sfa_pkg::QPW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [sfa_pkg::QCW-1:0]   count_ff, count_in;
   logic                      do_push, do_pop;

   assign full     = (count_ff == sfa_pkg::QCW'(sfa_pkg::QDEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == sfa_pkg::QPW'(sfa_pkg::QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == sfa_pkg::QPW'(sfa_pkg::QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   `SFA_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= sfa_pkg::QCW'(sfa_pkg::QDEPTH))
   `SFA_ASSERT_IMPLY(a_no_push_full, clock, reset, push, !full)
   `SFA_ASSERT_NEXT(a_fill_up, clock, reset, do_push && !do_pop, count_ff == $past(count_ff) + 1'b1)

endmodule

// ===== design/sfa_back.sv =====
// ----------------------------------------------------------------------------
// sfa_back
// length, scale and unit vector through a shared root and divide sequencer,
// saturating accumulation and the result register
// ----------------------------------------------------------------------------
`include "separation_force_accumulator_assert.svh"

module sfa_back (
   input  logic                  clock,
   input  logic                  reset,
   input  sfa_pkg::sfa_cfg_type  cfg,
   input  logic                  q_empty,
   input  sfa_pkg::sfa_work_type q_data,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output sfa_pkg::sfa_rsp_type  rsp_data
);

   localparam logic [sfa_pkg::MW-1:0]    CMAX    = sfa_pkg::MW'(1) << sfa_pkg::AW;
   localparam logic [sfa_pkg::UW-1:0]    UNIT_ONE = sfa_pkg::UW'(1) << sfa_pkg::FRAC_BITS;
   localparam logic [sfa_pkg::CNT_W-1:0] SQ_LAST  = sfa_pkg::CNT_W'(sfa_pkg::AXES);
   localparam logic [sfa_pkg::CNT_W-1:0] ROOT_LAST = sfa_pkg::CNT_W'(sfa_pkg::DW - 1);
   localparam logic [sfa_pkg::CNT_W-1:0] DIVS_LAST = sfa_pkg::CNT_W'(sfa_pkg::NW - 1);
   localparam logic [sfa_pkg::CNT_W-1:0] DIVU_LAST = sfa_pkg::CNT_W'(sfa_pkg::FRAC_BITS - 1);

   sfa_pkg::sfa_state_type        state_ff, state_in;
   logic [sfa_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [1:0]                    axis_ff, axis_in;
   logic                          out_valid_ff, out_valid_in;
   logic signed [sfa_pkg::POS_W-1:0] sum_ff [sfa_pkg::AXES];
   logic                          clip_ff;

   sfa_pkg::sfa_work_type         item_ff;
   logic [sfa_pkg::SQ_W-1:0]      sqr_ff, sq_acc_ff;
   logic [sfa_pkg::SQ_PAD-1:0]    sq_sh_ff;
   logic [sfa_pkg::DW-1:0]        root_ff;
   logic [sfa_pkg::SREM_W-1:0]    srem_ff;
   logic                          rd_neg_ff;
   logic [sfa_pkg::NW-1:0]        dvd_ff;
   logic [sfa_pkg::DW-1:0]        rem_ff, dsor_ff;
   logic                          div_scale_ff;
   logic [sfa_pkg::NW-1:0]        scale_ff;
   logic [sfa_pkg::UW-1:0]        unit_ff;
   logic [sfa_pkg::UW+sfa_pkg::SL-1:0] plo_ff;
   logic [sfa_pkg::UW+sfa_pkg::SH-1:0] phi_ff;
   logic signed [sfa_pkg::CW-1:0] contrib_ff;
   sfa_pkg::sfa_rsp_type          out_ff;

   logic                          emit;
   logic                          div_last;
   logic [sfa_pkg::DW-1:0]        rad_eff;
   logic [sfa_pkg::SREM_W+1:0]    root_cur, root_trial;
   logic                          root_ge;
   logic [sfa_pkg::SREM_W-1:0]    srem_step;
   logic [sfa_pkg::DW:0]          div_cur;
   logic                          div_ge;
   logic [sfa_pkg::DW-1:0]        rem_step;
   logic [sfa_pkg::NW-1:0]        dvd_step;
   logic [sfa_pkg::AW-1:0]        axis_mag;
   logic signed [sfa_pkg::CW-1:0] contrib_calc;
   logic signed [sfa_pkg::POS_W-1:0] sum_calc;
   logic                          clip_calc;

   // zero radius behaves as one raw unit
   assign rad_eff = (cfg.radius == '0) ? sfa_pkg::DW'(1) : sfa_pkg::DW'(cfg.radius);
   assign axis_mag = item_ff.mag[axis_ff];

   // one digit of the square root
   assign root_cur   = {srem_ff, sq_sh_ff[sfa_pkg::SQ_PAD-1 -: 2]};
   assign root_trial = (sfa_pkg::SREM_W + 2)'({root_ff, 2'b01});
   assign root_ge    = (root_cur >= root_trial);
   assign srem_step  = root_ge ? sfa_pkg::SREM_W'(root_cur - root_trial)
                               : root_cur[sfa_pkg::SREM_W-1:0];

   // one bit of the restoring divider
   assign div_cur  = {rem_ff, dvd_ff[sfa_pkg::NW-1]};
   assign div_ge   = (div_cur >= {1'b0, dsor_ff});
   assign rem_step = div_ge ? sfa_pkg::DW'(div_cur - {1'b0, dsor_ff})
                            : div_cur[sfa_pkg::DW-1:0];
   assign dvd_step = {dvd_ff[sfa_pkg::NW-2:0], div_ge};
   assign div_last = div_scale_ff ? (cnt_ff == DIVS_LAST) : (cnt_ff == DIVU_LAST);

   // rescale, clamp and sign of one axis contribution
   always_comb begin
      logic [sfa_pkg::PW-1:0] prod;
      logic [sfa_pkg::MW-1:0] shifted, clamped;
      prod    = sfa_pkg::PW'(plo_ff) + (sfa_pkg::PW'(phi_ff) << sfa_pkg::SL);
      shifted = prod[sfa_pkg::PW-1:sfa_pkg::FRAC_BITS];
      clamped = (shifted > CMAX) ? CMAX : shifted;
      if (item_ff.neg[axis_ff] ^ rd_neg_ff) begin
         contrib_calc = -sfa_pkg::CW'(clamped[sfa_pkg::AW:0]);
      end else begin
         contrib_calc = sfa_pkg::CW'(clamped[sfa_pkg::AW:0]);
      end
   end

   // saturating add into the selected axis
   always_comb begin
      logic signed [sfa_pkg::ACC_W-1:0] t;
      logic signed [sfa_pkg::POS_W-1:0] cur;
      cur = sum_ff[axis_ff];
      t   = {{(sfa_pkg::ACC_W - sfa_pkg::POS_W){cur[sfa_pkg::POS_W-1]}}, cur}
          + {contrib_ff[sfa_pkg::CW-1], contrib_ff};
      clip_calc = !((&t[sfa_pkg::ACC_W-1:sfa_pkg::POS_W-1]) ||
                    !(|t[sfa_pkg::ACC_W-1:sfa_pkg::POS_W-1]));
      if (!clip_calc) begin
         sum_calc = t[sfa_pkg::POS_W-1:0];
      end else if (t[sfa_pkg::ACC_W-1]) begin
         sum_calc = {1'b1, {(sfa_pkg::POS_W-1){1'b0}}};
      end else begin
         sum_calc = {1'b0, {(sfa_pkg::POS_W-1){1'b1}}};
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      axis_in  = axis_ff;
      case (state_ff)
         sfa_pkg::ST_IDLE: begin
            if (!q_empty) begin
               cnt_in  = '0;
               axis_in = '0;
               case (q_data.kind)
                  sfa_pkg::KIND_CLOSE: state_in = sfa_pkg::ST_DONE;
                  sfa_pkg::KIND_COIN:  state_in = sfa_pkg::ST_FALLBACK;
                  default:             state_in = sfa_pkg::ST_SQUARE;
               endcase
            end
         end
         sfa_pkg::ST_SQUARE: begin
            if (cnt_ff == SQ_LAST) begin
               cnt_in   = '0;
               state_in = sfa_pkg::ST_ROOT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         sfa_pkg::ST_ROOT: begin
            if (cnt_ff == ROOT_LAST) begin
               state_in = sfa_pkg::ST_SCALE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         sfa_pkg::ST_SCALE: begin
            cnt_in   = '0;
            state_in = sfa_pkg::ST_DIV;
         end
         sfa_pkg::ST_DIV: begin
            if (div_last) begin
               state_in = div_scale_ff ? sfa_pkg::ST_UNIT : sfa_pkg::ST_MUL_LO;
               axis_in  = div_scale_ff ? 2'd0 : axis_ff;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         sfa_pkg::ST_UNIT: begin
            cnt_in   = '0;
            state_in = (sfa_pkg::DW'(axis_mag) >= root_ff) ? sfa_pkg::ST_MUL_LO
                                                          : sfa_pkg::ST_DIV;
         end
         sfa_pkg::ST_MUL_LO:   state_in = sfa_pkg::ST_MUL_HI;
         sfa_pkg::ST_MUL_HI:   state_in = sfa_pkg::ST_PRODUCT;
         sfa_pkg::ST_PRODUCT:  state_in = sfa_pkg::ST_ACC;
         sfa_pkg::ST_FALLBACK: state_in = sfa_pkg::ST_ACC;
         sfa_pkg::ST_ACC: begin
            if (item_ff.kind == sfa_pkg::KIND_COIN) begin
               if (axis_ff == 2'd0) begin
                  axis_in = 2'd2;
               end else begin
                  state_in = sfa_pkg::ST_DONE;
               end
            end else if (axis_ff == 2'(sfa_pkg::AXES - 1)) begin
               state_in = sfa_pkg::ST_DONE;
            end else begin
               axis_in  = axis_ff + 1'b1;
               state_in = sfa_pkg::ST_UNIT;
            end
         end
         sfa_pkg::ST_DONE: begin
            if (!item_ff.last || emit) begin
               state_in = sfa_pkg::ST_IDLE;
            end
         end
         default: state_in = sfa_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      q_pop = (state_ff == sfa_pkg::ST_IDLE) && !q_empty;
      emit  = (state_ff == sfa_pkg::ST_DONE) && item_ff.last && (!out_valid_ff || rsp_pop);
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   // control state and sums
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sfa_pkg::ST_IDLE;
         cnt_ff       <= '0;
         axis_ff      <= '0;
         out_valid_ff <= 1'b0;
         clip_ff      <= 1'b0;
         for (int i = 0; i < sfa_pkg::AXES; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         axis_ff      <= axis_in;
         out_valid_ff <= out_valid_in;
         if (state_ff == sfa_pkg::ST_ACC) begin
            sum_ff[axis_ff] <= sum_calc;
            clip_ff         <= clip_ff || clip_calc;
         end else if (emit) begin
            clip_ff <= 1'b0;
            for (int i = 0; i < sfa_pkg::AXES; i++) begin
               sum_ff[i] <= '0;
            end
         end
      end
   end

   // arithmetic datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         sfa_pkg::ST_IDLE: begin
            if (q_pop) begin
               item_ff <= q_data;
            end
         end
         sfa_pkg::ST_SQUARE: begin
            if (cnt_ff < SQ_LAST) begin
               sqr_ff <= item_ff.mag[cnt_ff[1:0]] * item_ff.mag[cnt_ff[1:0]];
            end
            if (cnt_ff == '0) begin
               sq_acc_ff <= '0;
            end else begin
               sq_acc_ff <= sq_acc_ff + sqr_ff;
            end
            if (cnt_ff == SQ_LAST) begin
               sq_sh_ff <= sfa_pkg::SQ_PAD'(sq_acc_ff + sqr_ff);
               root_ff  <= '0;
               srem_ff  <= '0;
            end
         end
         sfa_pkg::ST_ROOT: begin
            sq_sh_ff <= sq_sh_ff << 2;
            srem_ff  <= srem_step;
            root_ff  <= {root_ff[sfa_pkg::DW-2:0], root_ge};
         end
         sfa_pkg::ST_SCALE: begin
            rd_neg_ff    <= (root_ff > rad_eff);
            rem_ff       <= '0;
            dsor_ff      <= rad_eff;
            div_scale_ff <= 1'b1;
            if (root_ff > rad_eff) begin
               dvd_ff <= sfa_pkg::NW'(root_ff - rad_eff) << sfa_pkg::FRAC_BITS;
            end else begin
               dvd_ff <= sfa_pkg::NW'(rad_eff - root_ff) << sfa_pkg::FRAC_BITS;
            end
         end
         sfa_pkg::ST_DIV: begin
            rem_ff <= rem_step;
            dvd_ff <= dvd_step;
            if (div_last && div_scale_ff) begin
               scale_ff <= dvd_step;
            end
            if (div_last && !div_scale_ff) begin
               unit_ff <= dvd_step[sfa_pkg::UW-1:0];
            end
         end
         sfa_pkg::ST_UNIT: begin
            rem_ff       <= sfa_pkg::DW'(axis_mag);
            dvd_ff       <= '0;
            dsor_ff      <= root_ff;
            div_scale_ff <= 1'b0;
            unit_ff      <= UNIT_ONE;
         end
         sfa_pkg::ST_MUL_LO: plo_ff <= unit_ff * scale_ff[sfa_pkg::SL-1:0];
         sfa_pkg::ST_MUL_HI: phi_ff <= unit_ff * scale_ff[sfa_pkg::NW-1:sfa_pkg::SL];
         sfa_pkg::ST_PRODUCT: contrib_ff <= contrib_calc;
         sfa_pkg::ST_FALLBACK: begin
            contrib_ff <= {{(sfa_pkg::CW - sfa_pkg::FB_W){cfg.fallback_x[sfa_pkg::FB_W-1]}},
                           cfg.fallback_x};
         end
         sfa_pkg::ST_ACC: begin
            contrib_ff <= {{(sfa_pkg::CW - sfa_pkg::FB_W){cfg.fallback_z[sfa_pkg::FB_W-1]}},
                           cfg.fallback_z};
         end
         sfa_pkg::ST_DONE: begin
            if (emit) begin
               out_ff.force_x   <= sum_ff[0];
               out_ff.force_y   <= sum_ff[1];
               out_ff.force_z   <= sum_ff[2];
               out_ff.saturated <= clip_ff;
            end
         end
         default: begin
         end
      endcase
   end

   `SFA_ASSERT_NEXT(a_result_held, clock, reset, out_valid_ff && !rsp_pop, out_valid_ff && $stable(out_ff))
   `SFA_ASSERT_IMPLY(a_root_range, clock, reset, state_ff == sfa_pkg::ST_SCALE, !root_ff[sfa_pkg::DW-1])
   `SFA_ASSERT_IMPLY(a_unit_range, clock, reset, state_ff == sfa_pkg::ST_MUL_LO, unit_ff <= UNIT_ONE)
   `SFA_ASSERT_IMPLY(a_coin_skips_y, clock, reset, state_ff == sfa_pkg::ST_ACC && item_ff.kind == sfa_pkg::KIND_COIN, axis_ff != 2'd1)

endmodule
